### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every assertion is clocked on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication of cons on ante, using the |=> operator.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fqvr_pkg.sv
// ----------------------------------------------------------------------------
// fqvr_pkg
// Types and constants that the FIFO queue with value removal shares.
// ----------------------------------------------------------------------------
`default_nettype none

package fqvr_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int DEF_QUEUE_DEPTH = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic                     shift;  // every cell takes its right neighbor
        logic                     write;  // the cell at the tail index loads value
        logic                     mark;   // every cell flags itself if equal to value
        logic signed [DATA_W-1:0] value;
    } ctrl_t;

endpackage

`default_nettype wire

### hdl/fqvr_if.sv
// ----------------------------------------------------------------------------
// fqvr_if
// Valid/ready channels: command requests and command responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface fqvr_req_if;
    import fqvr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output cmd, output data_value, input ready);
    modport sink   (input valid, input cmd, input data_value, output ready);
endinterface

interface fqvr_rsp_if #(
    parameter int CNT_W = 5
);
    import fqvr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         removed_count;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         fill_level;

    modport source (output valid, output read_value, output removed_count,
                    output status, output fill_level, input ready);
    modport sink   (input valid, input read_value, input removed_count,
                    input status, input fill_level, output ready);
endinterface

`default_nettype wire

### hdl/fqvr_cell.sv
// ----------------------------------------------------------------------------
// fqvr_cell
// One queue slot: holds a value and a removal flag, and can take its right
// neighbor's contents, load a broadcast value, or compare against it.
// ----------------------------------------------------------------------------
`default_nettype none

module fqvr_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  wire logic                             clk,
    input  wire fqvr_pkg::ctrl_t                  ctrl,
    input  wire logic [CNT_W-1:0]                 tail,
    input  wire logic signed [fqvr_pkg::DATA_W-1:0] right_value,
    input  wire logic                             right_dead,
    output logic signed [fqvr_pkg::DATA_W-1:0]    value,
    output logic                                  dead
);
    import fqvr_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     dead_reg;
    logic                     dead_next;
    logic                     at_tail;

    assign at_tail = (tail == CNT_W'(CELL_IDX));

    // Write wins over shift so a kept head lands at the tail while the row moves
    always_comb
    begin
        value_next = value_reg;
        dead_next  = dead_reg;
        if (ctrl.mark)
        begin
            dead_next = (value_reg == ctrl.value);
        end
        if (ctrl.shift)
        begin
            value_next = right_value;
            dead_next  = right_dead;
        end
        if (ctrl.write && at_tail)
        begin
            value_next = ctrl.value;
            dead_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        dead_reg  <= dead_next;
    end

    assign value = value_reg;
    assign dead  = dead_reg;

endmodule

`default_nettype wire

### hdl/fifo_queue_with_value_removal.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_value_removal
// Bounded FIFO of signed 32-bit values with push, pop and remove-by-value.
// ----------------------------------------------------------------------------
// Entries sit in a row of QUEUE_DEPTH cells with the head in cell 0. A push
// or a pop completes in the cycle it is accepted, and its response is held
// in an output register, so pushes and pops run at one per cycle while the
// response side keeps up. A remove on an empty queue responds at once;
// otherwise every matching cell is first flagged, then the row rotates once
// per cycle for n steps, n being the fill level, dropping a flagged head or
// recycling a kept head to the tail. No request is taken during that walk.
// Unused command codes respond at once with the current fill level.
`default_nettype none

module fifo_queue_with_value_removal #(
    parameter int QUEUE_DEPTH = fqvr_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fqvr_req_if.sink  req,
    fqvr_rsp_if.source rsp
);
    import fqvr_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] steps_reg;
    logic [CNT_W-1:0] steps_next;
    logic [CNT_W-1:0] removed_reg;
    logic [CNT_W-1:0] removed_next;

    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [CNT_W-1:0]         removed_count_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [CNT_W-1:0]         fill_level_reg;

    logic                     accept;
    logic                     res_load;
    logic signed [DATA_W-1:0] res_read;
    logic [CNT_W-1:0]         res_removed;
    logic [STATUS_W-1:0]      res_status;

    ctrl_t                    ctrl;
    logic [CNT_W-1:0]         tail;
    logic signed [DATA_W-1:0] cell_value [QUEUE_DEPTH];
    logic                     cell_dead  [QUEUE_DEPTH];

    // Handshake: take a request when idle and the response slot frees up
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // Command decode and removal walk
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        removed_next = removed_reg;
        ctrl         = '0;
        tail         = count_reg;
        res_load     = 1'b0;
        res_read     = '0;
        res_removed  = '0;
        res_status   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_PUSH:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.write = 1'b1;
                                ctrl.value = req.data_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                res_read   = cell_value[0];
                                ctrl.shift = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                ctrl.mark    = 1'b1;
                                ctrl.value   = req.data_value;
                                steps_next   = count_reg;
                                removed_next = '0;
                                state_next   = S_WALK;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Head leaves the row; a kept head re-enters at the tail
                ctrl.shift = 1'b1;
                ctrl.write = !cell_dead[0];
                ctrl.value = cell_value[0];
                tail       = count_reg - 1'b1;
                if (cell_dead[0])
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end
                steps_next = steps_reg - 1'b1;
                if (steps_reg == CNT_W'(1))
                begin
                    res_load    = 1'b1;
                    res_removed = removed_next;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            steps_reg   <= steps_next;
            removed_reg <= removed_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            read_value_reg    <= res_read;
            removed_count_reg <= res_removed;
            status_reg        <= res_status;
            fill_level_reg    <= count_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_value    = read_value_reg;
    assign rsp.removed_count = removed_count_reg;
    assign rsp.status        = status_reg;
    assign rsp.fill_level    = fill_level_reg;

    // Cell row, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] right_value;
        logic                     right_dead;

        if (i < QUEUE_DEPTH - 1)
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_dead  = cell_dead[i+1];
        end
        else
        begin : g_last
            assign right_value = '0;
            assign right_dead  = 1'b0;
        end

        fqvr_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .tail        (tail),
            .right_value (right_value),
            .right_dead  (right_dead),
            .value       (cell_value[i]),
            .dead        (cell_dead[i])
        );
    end

    // Assertions
    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "fill count beyond queue depth")
    `ASSERT_IMPL(a_walk_no_rsp, state_reg == S_WALK, !rsp_valid_reg,
        "response pending during removal walk")
    `ASSERT_NEXT(a_walk_no_grow, state_reg == S_WALK, count_reg <= $past(count_reg),
        "fill count grew during removal walk")
    `ASSERT_IMPL(a_walk_steps, state_reg == S_WALK,
        steps_reg != '0 && removed_reg + count_reg <= CNT_W'(QUEUE_DEPTH),
        "removal walk bookkeeping out of range")

endmodule

`default_nettype wire
